// ===== design/button_click_gesture_detector_unit_assert.svh =====
// Assertion macros for the checker file bcgd_chk.sv.
`ifndef BUTTON_CLICK_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_CLICK_GESTURE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BCGD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bcgd check failed");

// next-cycle implication
`define BCGD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bcgd check failed");

`endif

// ===== design/bcgd_pkg.sv =====
package bcgd_pkg;

  // number of buttons that have level and feature bits
  localparam int unsigned HW_BUTTONS = 6;
  // button index width used by the lookup functions (up to 16 buttons)
  localparam int unsigned IDX_W = 4;

  // reset values of the configuration registers
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] LONG_RST     = 16'd800;
  localparam logic [15:0] DOUBLE_RST   = 16'd300;
  localparam logic [17:0] FEAT_RST     = 18'h3FFFF;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_DOUBLE   = 2'd2,
    CFG_FEATURES = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_PRESS  = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } ev_kind_t;

  // feature bit positions within one button's three bits
  localparam int unsigned FEAT_SINGLE = 0;
  localparam int unsigned FEAT_DBL    = 1;
  localparam int unsigned FEAT_LNG    = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DEB,
    ST_TAIL,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] double_click_ms;
    logic [17:0] feature_masks;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [5:0]  pressed_levels;
    logic        pin_change;
  } in_t;

  typedef struct packed {
    logic [2:0] button_index;
    logic [1:0] event_kind;
    logic       last_event;
  } out_t;

  // one button's stored state
  typedef struct packed {
    logic        stable_level;
    logic        prior_stable_level;
    logic [31:0] change_stamp;
    logic [31:0] press_stamp;
    logic        long_fired;
    logic        click_waiting;
    logic [31:0] click_stamp;
  } btn_state_t;

  typedef struct packed {
    logic     vld;
    ev_kind_t kind;
  } ev_t;

  // sequencer to emitter: one event or the end-of-pass flush
  typedef struct packed {
    logic       vld;
    logic       flush;
    logic [2:0] idx;
    ev_kind_t   kind;
  } push_t;

  function automatic logic [2:0] feat_of(input logic [17:0] m, input logic [IDX_W-1:0] i);
    logic [2:0] f;
    unique case (i)
      4'd0:    f = m[2:0];
      4'd1:    f = m[5:3];
      4'd2:    f = m[8:6];
      4'd3:    f = m[11:9];
      4'd4:    f = m[14:12];
      4'd5:    f = m[17:15];
      default: f = 3'd0;
    endcase
    return f;
  endfunction

  function automatic logic phys_of(input logic [5:0] lv, input logic [IDX_W-1:0] i);
    logic p;
    p = (i < IDX_W'(HW_BUTTONS)) ? lv[i[2:0]] : 1'b0;
    return p;
  endfunction

endpackage

// ===== design/bcgd_ram.sv =====
module bcgd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bcgd_eval.sv =====
module bcgd_eval (
  input  bcgd_pkg::cfg_t       cfg,
  input  logic [31:0]          now,
  input  logic                 irq,
  input  logic                 phys,
  input  logic [2:0]           feat,
  input  bcgd_pkg::btn_state_t cur,
  input  bcgd_pkg::btn_state_t upd,
  output bcgd_pkg::btn_state_t deb_st,
  output bcgd_pkg::ev_t        deb_ev,
  output bcgd_pkg::btn_state_t tail_st,
  output bcgd_pkg::ev_t        long_ev,
  output bcgd_pkg::ev_t        to_ev
);

  logic [31:0] d_chg;
  logic [31:0] d_clk_deb;
  logic [31:0] d_press;
  logic [31:0] d_clk_tail;
  logic        take;

  assign d_chg      = now - cur.change_stamp;
  assign d_clk_deb  = now - cur.click_stamp;
  assign d_press    = now - upd.press_stamp;
  assign d_clk_tail = now - upd.click_stamp;

  // debounced level change and the press / release event it gives
  always_comb begin
    take   = irq && (feat != 3'd0) && (phys != cur.stable_level) &&
             (d_chg >= {16'd0, cfg.debounce_ms});
    deb_st = cur;
    deb_ev = '0;
    if (take) begin
      deb_st.prior_stable_level = cur.stable_level;
      deb_st.stable_level       = phys;
      deb_st.change_stamp       = now;
      if (phys) begin
        // prior level is always released here, so a press always fires
        deb_st.press_stamp = now;
        deb_st.long_fired  = 1'b0;
        deb_ev.vld         = 1'b1;
        deb_ev.kind        = bcgd_pkg::EV_PRESS;
      end else if (cur.long_fired) begin
        deb_st.long_fired    = 1'b0;
        deb_st.click_waiting = 1'b0;
      end else if (feat[bcgd_pkg::FEAT_DBL]) begin
        if (cur.click_waiting && (d_clk_deb <= {16'd0, cfg.double_click_ms})) begin
          deb_st.click_waiting = 1'b0;
          deb_ev.vld           = 1'b1;
          deb_ev.kind          = bcgd_pkg::EV_DOUBLE;
        end else begin
          deb_st.click_waiting = 1'b1;
          deb_st.click_stamp   = now;
        end
      end else if (feat[bcgd_pkg::FEAT_SINGLE]) begin
        deb_ev.vld  = 1'b1;
        deb_ev.kind = bcgd_pkg::EV_CLICK;
      end
    end
  end

  // long press, then double-click window timeout
  always_comb begin
    tail_st = upd;
    long_ev = '0;
    to_ev   = '0;
    if (feat[bcgd_pkg::FEAT_LNG] && upd.stable_level && !upd.long_fired &&
        (d_press >= {16'd0, cfg.long_press_ms})) begin
      tail_st.long_fired    = 1'b1;
      tail_st.click_waiting = 1'b0;
      long_ev.vld           = 1'b1;
      long_ev.kind          = bcgd_pkg::EV_LONG;
    end
    if (feat[bcgd_pkg::FEAT_DBL] && tail_st.click_waiting && !tail_st.long_fired &&
        (d_clk_tail >= {16'd0, cfg.double_click_ms})) begin
      tail_st.click_waiting = 1'b0;
      to_ev.vld             = feat[bcgd_pkg::FEAT_SINGLE];
      to_ev.kind            = bcgd_pkg::EV_CLICK;
    end
  end

endmodule

// ===== design/bcgd_emit.sv =====
module bcgd_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  bcgd_pkg::push_t push,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output bcgd_pkg::out_t  out_data
);

  logic              out_valid_r;
  bcgd_pkg::out_t    out_data_r;
  logic              hold_v_r;
  logic [2:0]        hold_idx_r;
  bcgd_pkg::ev_kind_t hold_kind_r;
  logic              out_free;
  logic              send;

  // one event is held back until we know whether it closes the pass
  assign out_free   = !out_valid_r || out_ready;
  assign push_ready = !hold_v_r || out_free;
  assign send       = push.vld && hold_v_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
    end else begin
      if (send) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (push.vld && push_ready) begin
        hold_v_r <= !push.flush;
      end
    end
  end

  // payload of the output beat and of the held event
  always_ff @(posedge clk) begin
    if (send) begin
      out_data_r.button_index <= hold_idx_r;
      out_data_r.event_kind   <= hold_kind_r;
      out_data_r.last_event   <= push.flush;
    end
    if (push.vld && push_ready && !push.flush) begin
      hold_idx_r  <= push.idx;
      hold_kind_r <= push.kind;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/button_click_gesture_detector_unit.sv =====
// Passes: buttons are visited one at a time, each through the states READ (state RAM read),
// DEB (debounce), TAIL (long/timeout + write-back) and EMIT (emit its events), then FLUSH.
// A new input is taken only once the pass is back in IDLE, set by the one-button-at-a-time
// read-modify-write of the per-button state RAM; output stalls lengthen a pass.
// Reset (rst_n, synchronous, active low): configuration returns to its defaults and
// every button's state reads as zero through per-entry valid bits; no clearing pass.
module button_click_gesture_detector_unit #(
  parameter int unsigned NUM_BUTTONS = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bcgd_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bcgd_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [17:0]     cfg_wdata
);

  localparam int unsigned BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned ST_W  = $bits(bcgd_pkg::btn_state_t);

  bcgd_pkg::cfg_t       cfg_r;
  bcgd_pkg::state_t     state_r, state_nxt;
  logic [BTN_W-1:0]     btn_r, btn_nxt;
  bcgd_pkg::in_t        in_r;
  logic [NUM_BUTTONS-1:0] vld_r;
  logic                 vld_q_r;
  bcgd_pkg::btn_state_t ent_r, ent_nxt;
  bcgd_pkg::ev_t [2:0]  evq_r, evq_nxt;

  logic                 ram_re;
  logic                 ram_we;
  logic [ST_W-1:0]      ram_rdata;
  bcgd_pkg::btn_state_t cur;
  bcgd_pkg::btn_state_t deb_st;
  bcgd_pkg::btn_state_t tail_st;
  bcgd_pkg::ev_t        deb_ev;
  bcgd_pkg::ev_t        long_ev;
  bcgd_pkg::ev_t        to_ev;
  logic [bcgd_pkg::IDX_W-1:0] btn_ix;
  logic [2:0]           feat;
  logic                 phys;
  logic                 last_btn;
  bcgd_pkg::push_t      push;
  logic                 push_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= bcgd_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms   <= bcgd_pkg::LONG_RST;
      cfg_r.double_click_ms <= bcgd_pkg::DOUBLE_RST;
      cfg_r.feature_masks   <= bcgd_pkg::FEAT_RST;
    end else if (cfg_we) begin
      unique case (bcgd_pkg::cfg_idx_t'(cfg_idx))
        bcgd_pkg::CFG_DEBOUNCE: cfg_r.debounce_ms     <= cfg_wdata[15:0];
        bcgd_pkg::CFG_LONG:     cfg_r.long_press_ms   <= cfg_wdata[15:0];
        bcgd_pkg::CFG_DOUBLE:   cfg_r.double_click_ms <= cfg_wdata[15:0];
        bcgd_pkg::CFG_FEATURES: cfg_r.feature_masks   <= cfg_wdata;
      endcase
    end
  end

  // per-button state memory
  bcgd_ram #(
    .WIDTH (ST_W),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (btn_r),
    .wdata (tail_st),
    .re    (ram_re),
    .raddr (btn_r),
    .rdata (ram_rdata)
  );

  // never-written entries read as the reset state
  assign cur      = vld_q_r ? bcgd_pkg::btn_state_t'(ram_rdata) : '0;
  assign btn_ix   = bcgd_pkg::IDX_W'(btn_r);
  assign feat     = bcgd_pkg::feat_of(cfg_r.feature_masks, btn_ix);
  assign phys     = bcgd_pkg::phys_of(in_r.pressed_levels, btn_ix);
  assign last_btn = (btn_r == BTN_W'(NUM_BUTTONS - 1));

  bcgd_eval u_eval (
    .cfg     (cfg_r),
    .now     (in_r.now_ms),
    .irq     (in_r.pin_change),
    .phys    (phys),
    .feat    (feat),
    .cur     (cur),
    .upd     (ent_r),
    .deb_st  (deb_st),
    .deb_ev  (deb_ev),
    .tail_st (tail_st),
    .long_ev (long_ev),
    .to_ev   (to_ev)
  );

  bcgd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcgd_pkg::ST_IDLE;
      btn_r   <= '0;
      evq_r   <= '0;
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      btn_r   <= btn_nxt;
      evq_r   <= evq_nxt;
      if (ram_we) begin
        vld_r[btn_r] <= 1'b1;
      end
      if (ram_re) begin
        vld_q_r <= vld_r[btn_r];
      end
    end
  end

  // pass inputs and the debounced entry
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    ent_r <= ent_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    btn_nxt   = btn_r;
    evq_nxt   = evq_r;
    ent_nxt   = ent_r;
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    push      = '0;
    push.idx  = 3'(btn_ix);
    unique case (state_r)
      bcgd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          btn_nxt   = '0;
          state_nxt = bcgd_pkg::ST_READ;
        end
      end
      bcgd_pkg::ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = bcgd_pkg::ST_DEB;
      end
      bcgd_pkg::ST_DEB: begin
        ent_nxt    = deb_st;
        evq_nxt[0] = deb_ev;
        evq_nxt[1] = '0;
        evq_nxt[2] = '0;
        state_nxt  = bcgd_pkg::ST_TAIL;
      end
      bcgd_pkg::ST_TAIL: begin
        ram_we     = 1'b1;
        evq_nxt[1] = long_ev;
        evq_nxt[2] = to_ev;
        state_nxt  = bcgd_pkg::ST_EMIT;
      end
      bcgd_pkg::ST_EMIT: begin
        // events of this button in order: press/release, long, timeout
        if (evq_r[0].vld) begin
          push.vld  = 1'b1;
          push.kind = evq_r[0].kind;
          if (push_ready) evq_nxt[0].vld = 1'b0;
        end else if (evq_r[1].vld) begin
          push.vld  = 1'b1;
          push.kind = evq_r[1].kind;
          if (push_ready) evq_nxt[1].vld = 1'b0;
        end else if (evq_r[2].vld) begin
          push.vld  = 1'b1;
          push.kind = evq_r[2].kind;
          if (push_ready) evq_nxt[2].vld = 1'b0;
        end else if (last_btn) begin
          state_nxt = bcgd_pkg::ST_FLUSH;
        end else begin
          btn_nxt   = btn_r + 1'b1;
          state_nxt = bcgd_pkg::ST_READ;
        end
      end
      bcgd_pkg::ST_FLUSH: begin
        // release the held event, if any, with last_event set
        push.vld   = 1'b1;
        push.flush = 1'b1;
        if (push_ready) state_nxt = bcgd_pkg::ST_IDLE;
      end
      default: state_nxt = bcgd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/bcgd_chk.sv =====
`include "button_click_gesture_detector_unit_assert.svh"

module bcgd_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input bcgd_pkg::out_t out_data
);

  // a stalled result beat holds
  `BCGD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // in_ready is low in the cycle after an input is accepted
  `BCGD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // only buttons with pins can report events
  `BCGD_ASSERT_NOW(a_btn_range, clk, rst_n, out_valid, out_data.button_index < 3'd6)

endmodule

bind button_click_gesture_detector_unit bcgd_chk u_bcgd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/testbench.sv =====
module testbench;

  localparam int unsigned RUN_LIMIT    = 2000000;
  // time for a silent pass over all buttons and the flush, with margin
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned SETTLE_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  bcgd_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  bcgd_pkg::out_t out_data;
  logic           cfg_we;
  logic [1:0]     cfg_idx;
  logic [17:0]    cfg_wdata;

  button_click_gesture_detector_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shared run control
  bit             idle_on      = 1'b1;
  bit             hold_request = 1'b0;
  int             fail_count   = 0;
  int unsigned    cycle_count  = 0;
  bcgd_pkg::out_t expected_events [$];

  // predictor copy of the registers
  logic [15:0] btn_debounce;
  logic [15:0] hold_limit;
  logic [15:0] double_window;
  logic [17:0] btn_features;

  // predictor copy of the per-button state
  logic        stable_q   [bcgd_pkg::HW_BUTTONS];
  logic        prior_q    [bcgd_pkg::HW_BUTTONS];
  logic [31:0] change_at  [bcgd_pkg::HW_BUTTONS];
  logic [31:0] press_at   [bcgd_pkg::HW_BUTTONS];
  logic        long_done  [bcgd_pkg::HW_BUTTONS];
  logic        click_wait [bcgd_pkg::HW_BUTTONS];
  logic [31:0] click_at   [bcgd_pkg::HW_BUTTONS];

  // gesture generator state
  logic [31:0] clock_ms;
  logic [5:0]  held;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int unsigned random_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] elapsed(input logic [31:0] now, input logic [31:0] since);
    return now - since;
  endfunction

  function automatic bcgd_pkg::out_t make_event(input int b, input bcgd_pkg::ev_kind_t kind);
    bcgd_pkg::out_t e;
    e.button_index = 3'(b);
    e.event_kind   = kind;
    e.last_event   = 1'b0;
    return e;
  endfunction

  // one update pass over all buttons; queues the events it yields
  function automatic void predict_events(input bcgd_pkg::in_t item);
    bcgd_pkg::out_t found [$];
    bcgd_pkg::out_t ev;
    logic [2:0]     feat;
    logic           phys;
    logic [31:0]    now;
    int             b;
    int             k;
    now = item.now_ms;
    for (b = 0; b < bcgd_pkg::HW_BUTTONS; b++) begin
      feat = btn_features[3*b +: 3];
      phys = item.pressed_levels[b];
      // debounced level change
      if (item.pin_change && feat != 3'd0 && phys != stable_q[b] &&
          elapsed(now, change_at[b]) >= 32'(btn_debounce)) begin
        prior_q[b]   = stable_q[b];
        stable_q[b]  = phys;
        change_at[b] = now;
        if (phys) begin
          press_at[b]  = now;
          long_done[b] = 1'b0;
          if (!prior_q[b]) found.push_back(make_event(b, bcgd_pkg::EV_PRESS));
        end else if (long_done[b]) begin
          // release after long press is silent
          long_done[b]  = 1'b0;
          click_wait[b] = 1'b0;
        end else if (feat[bcgd_pkg::FEAT_DBL]) begin
          if (click_wait[b] && elapsed(now, click_at[b]) <= 32'(double_window)) begin
            click_wait[b] = 1'b0;
            found.push_back(make_event(b, bcgd_pkg::EV_DOUBLE));
          end else begin
            click_wait[b] = 1'b1;
            click_at[b]   = now;
          end
        end else if (feat[bcgd_pkg::FEAT_SINGLE]) begin
          found.push_back(make_event(b, bcgd_pkg::EV_CLICK));
        end
      end
      // long press while held
      if (feat[bcgd_pkg::FEAT_LNG] && stable_q[b] && !long_done[b] &&
          elapsed(now, press_at[b]) >= 32'(hold_limit)) begin
        long_done[b]  = 1'b1;
        click_wait[b] = 1'b0;
        found.push_back(make_event(b, bcgd_pkg::EV_LONG));
      end
      // double-click window ran out
      if (feat[bcgd_pkg::FEAT_DBL] && click_wait[b] && !long_done[b] &&
          elapsed(now, click_at[b]) >= 32'(double_window)) begin
        if (feat[bcgd_pkg::FEAT_SINGLE]) found.push_back(make_event(b, bcgd_pkg::EV_CLICK));
        click_wait[b] = 1'b0;
      end
    end
    for (k = 0; k < found.size(); k++) begin
      ev = found[k];
      ev.last_event = (k == found.size() - 1);
      expected_events.push_back(ev);
    end
  endfunction

  // hold one input beat until the block takes it, then maybe idle
  task automatic send_pass(input bcgd_pkg::in_t item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_events(item);
    gap = idle_on ? random_pause() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_levels(input logic [31:0] t, input logic [5:0] lv, input logic pin);
    bcgd_pkg::in_t item;
    item.now_ms         = t;
    item.pressed_levels = lv;
    item.pin_change     = pin;
    send_pass(item);
  endtask

  // wait for all expected events, then let a silent pass finish
  task automatic settle();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_events.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      fail_count++;
      expected_events.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all four registers back to back; block must be idle
  task automatic configure(input logic [17:0] deb, input logic [17:0] lng,
                           input logic [17:0] dbl, input logic [17:0] feat);
    bcgd_pkg::cfg_idx_t regs [4];
    logic [17:0]        vals [4];
    int                 k;
    regs = '{bcgd_pkg::CFG_DEBOUNCE, bcgd_pkg::CFG_LONG, bcgd_pkg::CFG_DOUBLE,
             bcgd_pkg::CFG_FEATURES};
    vals = '{deb, lng, dbl, feat};
    for (k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    btn_debounce  = deb[15:0];
    hold_limit    = lng[15:0];
    double_window = dbl[15:0];
    btn_features  = feat;
  endtask

  // button activity: level toggles with mixed spacing, mostly with the pin flag
  task automatic run_gestures(input int count, input int unsigned spread);
    bcgd_pkg::in_t item;
    int            k;
    int unsigned   r;
    int unsigned   bit_sel;
    logic [5:0]    next;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) clock_ms += $urandom_range(0, spread / 4);
      else if (r < 90) clock_ms += $urandom_range(spread / 4, spread * 2);
      else if (r < 97) clock_ms += $urandom_range(spread * 2, spread * 10);
      else clock_ms += $urandom;
      r = $urandom_range(0, 99);
      next = held;
      if (r < 50) begin
        bit_sel = $urandom_range(0, bcgd_pkg::HW_BUTTONS - 1);
        next[bit_sel] = ~next[bit_sel];
      end else if (r < 65) begin
        next = 6'($urandom);
      end
      item.now_ms         = clock_ms;
      item.pressed_levels = next;
      item.pin_change     = (next != held) ? ($urandom_range(0, 9) != 0)
                                           : ($urandom_range(0, 9) == 0);
      held = next;
      send_pass(item);
    end
  endtask

  // defaults: bounce, click, double click, long press, timeout click, wrap
  task automatic test_basic_gestures();
    send_levels(32'd1000, 6'b000001, 1'b1);
    send_levels(32'd1020, 6'b000000, 1'b1);
    send_levels(32'd1100, 6'b000000, 1'b1);
    send_levels(32'd1200, 6'b000001, 1'b1);
    send_levels(32'd1300, 6'b000000, 1'b1);
    send_levels(32'd2000, 6'b000000, 1'b0);
    send_levels(32'd3000, 6'b000010, 1'b1);
    send_levels(32'd3900, 6'b000010, 1'b0);
    send_levels(32'd4000, 6'b000000, 1'b1);
    send_levels(32'd5000, 6'b000100, 1'b1);
    send_levels(32'd5100, 6'b000000, 1'b1);
    send_levels(32'd5500, 6'b000000, 1'b0);
    send_levels(32'd6000, 6'b111111, 1'b1);
    send_levels(32'd6100, 6'b000000, 1'b1);
    send_levels(32'd7000, 6'b000000, 1'b0);
    send_levels(32'hFFFF_FFF0, 6'b001000, 1'b1);
    send_levels(32'h0000_0030, 6'b001000, 1'b0);
    send_levels(32'h0000_0030, 6'b000000, 1'b1);
    send_levels(32'h0000_0200, 6'b000001, 1'b0);
  endtask

  // per-button feature mixes with zero timings: no features, single only,
  // double only, long only, single+double, all
  task automatic test_feature_combinations();
    settle();
    configure(18'd0, 18'd0, 18'd0,
              {3'b111, 3'b011, 3'b100, 3'b010, 3'b001, 3'b000});
    send_levels(32'd10000, 6'b111111, 1'b1);
    send_levels(32'd10000, 6'b000000, 1'b1);
    send_levels(32'd10001, 6'b111111, 1'b1);
    send_levels(32'd10002, 6'b000000, 1'b1);
    send_levels(32'd10003, 6'b111111, 1'b1);
    send_levels(32'd10003, 6'b111111, 1'b0);
  endtask

  task automatic test_gesture_stream();
    settle();
    configure(18'd20, 18'd400, 18'd150, bcgd_pkg::FEAT_RST);
    clock_ms = $urandom;
    held     = '0;
    run_gestures(140, 150);
  endtask

  task automatic test_random_settings();
    int round;
    for (round = 0; round < 4; round++) begin
      settle();
      configure({2'($urandom), 16'($urandom_range(0, 100))},
                {2'($urandom), 16'($urandom_range(0, 1000))},
                {2'($urandom), 16'($urandom_range(0, 500))},
                18'($urandom));
      run_gestures(25, 200);
    end
  endtask

  // all windows at their maximum; upper write bits must be dropped
  task automatic test_slow_settings();
    settle();
    configure(18'h0FFFF, 18'h3FFFF, 18'h0FFFF, bcgd_pkg::FEAT_RST);
    run_gestures(60, 20000);
  endtask

  task automatic test_back_to_back();
    settle();
    configure(18'(bcgd_pkg::DEBOUNCE_RST), 18'(bcgd_pkg::LONG_RST),
              18'(bcgd_pkg::DOUBLE_RST), bcgd_pkg::FEAT_RST);
    idle_on = 1'b0;
    run_gestures(80, 300);
    idle_on = 1'b1;
  endtask

  // sink stops for a long stretch while passes keep coming
  task automatic test_output_backpressure();
    settle();
    configure(18'd5, 18'd100, 18'd50, bcgd_pkg::FEAT_RST);
    idle_on      = 1'b0;
    hold_request = 1'b1;
    run_gestures(30, 60);
    idle_on = 1'b1;
  endtask

  task automatic test_noise();
    bcgd_pkg::in_t item;
    int            k;
    int            half;
    for (half = 0; half < 2; half++) begin
      settle();
      configure(18'($urandom), 18'($urandom), 18'($urandom),
                (half == 0) ? 18'd0 : bcgd_pkg::FEAT_RST);
      for (k = 0; k < 20; k++) begin
        item.now_ms         = $urandom;
        item.pressed_levels = 6'($urandom);
        item.pin_change     = 1'($urandom);
        send_pass(item);
      end
    end
  endtask

  // result sink: random stalls, or one long hold on request
  initial begin : result_sink
    int unsigned pause;
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        pause = idle_on ? random_pause() : 0;
        if (pause != 0) begin
          out_ready <= 1'b0;
          repeat (pause) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // compare each accepted result beat with the oldest expected event
  always @(posedge clk) begin : event_check
    bcgd_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $error("event with nothing expected: button_index %0d event_kind %0d",
               out_data.button_index, out_data.event_kind);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_data.button_index !== want.button_index) begin
          $error("button_index: expected %0d, got %0d", want.button_index,
                 out_data.button_index);
          fail_count++;
        end
        if (out_data.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, got %0d", want.event_kind,
                 out_data.event_kind);
          fail_count++;
        end
        if (out_data.last_event !== want.last_event) begin
          $error("last_event: expected %0d, got %0d", want.last_event,
                 out_data.last_event);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int b;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= bcgd_pkg::CFG_DEBOUNCE;
    cfg_wdata <= '0;
    btn_debounce  = bcgd_pkg::DEBOUNCE_RST;
    hold_limit    = bcgd_pkg::LONG_RST;
    double_window = bcgd_pkg::DOUBLE_RST;
    btn_features  = bcgd_pkg::FEAT_RST;
    for (b = 0; b < bcgd_pkg::HW_BUTTONS; b++) begin
      stable_q[b]   = 1'b0;
      prior_q[b]    = 1'b0;
      change_at[b]  = '0;
      press_at[b]   = '0;
      long_done[b]  = 1'b0;
      click_wait[b] = 1'b0;
      click_at[b]   = '0;
    end
    clock_ms = '0;
    held     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_gestures();
    test_feature_combinations();
    test_gesture_stream();
    test_random_settings();
    test_slow_settings();
    test_back_to_back();
    test_output_backpressure();
    test_noise();
    settle();

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bcgd_pkg.sv
design/bcgd_ram.sv
design/bcgd_eval.sv
design/bcgd_emit.sv
design/button_click_gesture_detector_unit.sv
design/bcgd_chk.sv
tb/sv/testbench.sv
